/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the RTL folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

/* hw/rtl/crm_pkg.sv */
// ----------------------------------------------------------------------------
// crm_pkg
// Types and constants of the convolution / ReLU / max-pool layer engine.
// ----------------------------------------------------------------------------
package crm_pkg;

   // Default geometry
   localparam int NUM_CHANNELS_DEF = 16;
   localparam int CONV_SIZE_DEF    = 32;
   localparam int KERNEL_DEF       = 5;

   // Fixed field widths
   localparam int SAMPLE_W = 16;   // signed Q8.8
   localparam int BIAS_W   = 32;   // signed Q16.16
   localparam int PROD_W   = 32;   // Q16.16 product
   localparam int ACC_W    = 48;   // wrapping accumulator
   localparam int OUT_W    = 31;   // saturated unsigned Q15.16

   // Request kinds carried on tuser
   typedef enum logic [1:0] {
      REQ_PIXEL   = 2'd0,
      REQ_WEIGHT  = 2'd1,
      REQ_BIAS    = 2'd2,
      REQ_COMPUTE = 2'd3
   } req_kind_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MAC,
      ST_DRAIN,
      ST_POOL,
      ST_DONE
   } state_type;

endpackage

/* hw/rtl/conv_relu_maxpool_layer.sv */
// Throughput: compute words are handled one at a time by the single multiply-accumulate unit fed
//   by one read port of each store; no request is taken until the sequencer is idle again, and
//   loads go one per cycle while it is idle.
// Reset: synchronous, clears sequencer and handshake state; stores hold unknown data until written.
// ----------------------------------------------------------------------------
// conv_relu_maxpool_layer
// Convolution layer engine: one shared MAC walks channels and kernel taps for
// each of four conv points, applies ReLU and saturation, keeps the 2x2 maximum.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module conv_relu_maxpool_layer #(
   parameter int NUM_CHANNELS = crm_pkg::NUM_CHANNELS_DEF,
   parameter int CONV_SIZE    = crm_pkg::CONV_SIZE_DEF,
   parameter int KERNEL       = crm_pkg::KERNEL_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   // out_channel[3:0] in_channel[7:4] row[13:8] col[19:14] kernel_row[22:20]
   // kernel_col[25:23] sample[41:26] bias_value[73:42], zero pad [79:74]
   input  logic [79:0] req_tdata,
   // req_type[1:0]
   input  logic [1:0]  req_tuser,
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // res_channel[3:0] res_row[7:4] res_col[11:8] pooled_value[42:12], zero pad [47:43]
   output logic [47:0] rsp_tdata
);

   // Geometry
   localparam int IMG        = CONV_SIZE + KERNEL - 1;
   localparam int POOL_SIDE  = CONV_SIZE / 2;
   localparam int TAPS       = KERNEL * KERNEL;
   localparam int IN_DEPTH   = NUM_CHANNELS * IMG * IMG;
   localparam int WT_DEPTH   = NUM_CHANNELS * NUM_CHANNELS * TAPS;
   localparam int IN_AW      = (IN_DEPTH > 1) ? $clog2(IN_DEPTH) : 1;
   localparam int WT_AW      = (WT_DEPTH > 1) ? $clog2(WT_DEPTH) : 1;
   localparam int CH_W       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int K_W        = (KERNEL > 1) ? $clog2(KERNEL) : 1;
   localparam int IN_STEP_ROW = IMG - KERNEL + 1;
   localparam int IN_STEP_CH  = IMG * IMG - (KERNEL - 1) * IMG - (KERNEL - 1);
   localparam int SAT_HI     = crm_pkg::ACC_W - 2;
   localparam int EXT_W      = crm_pkg::ACC_W - crm_pkg::BIAS_W;
   localparam int PEXT_W     = crm_pkg::ACC_W - crm_pkg::PROD_W;

   // Request word fields
   crm_pkg::req_kind_type       req_kind;
   logic [3:0]                  req_oc;
   logic [3:0]                  req_ic;
   logic [5:0]                  req_row;
   logic [5:0]                  req_col;
   logic [2:0]                  req_krow;
   logic [2:0]                  req_kcol;
   logic [crm_pkg::SAMPLE_W-1:0] req_sample;
   logic [crm_pkg::BIAS_W-1:0]   req_bias;

   assign req_kind   = crm_pkg::req_kind_type'(req_tuser);
   assign req_oc     = req_tdata[3:0];
   assign req_ic     = req_tdata[7:4];
   assign req_row    = req_tdata[13:8];
   assign req_col    = req_tdata[19:14];
   assign req_krow   = req_tdata[22:20];
   assign req_kcol   = req_tdata[25:23];
   assign req_sample = req_tdata[41:26];
   assign req_bias   = req_tdata[73:42];

   // Stores
   logic [crm_pkg::SAMPLE_W-1:0] in_mem [IN_DEPTH];
   logic [crm_pkg::SAMPLE_W-1:0] wt_mem [WT_DEPTH];
   logic [crm_pkg::BIAS_W-1:0]   bias_mem [NUM_CHANNELS];

   // Sequencer and datapath registers
   crm_pkg::state_type state_ff, state_in;
   logic [IN_AW-1:0]            pos_base_ff;
   logic [WT_AW-1:0]            wt_base_ff;
   logic [IN_AW-1:0]            in_addr_ff;
   logic [WT_AW-1:0]            wt_addr_ff;
   logic [CH_W-1:0]             j_ff;
   logic [K_W-1:0]              p_ff;
   logic [K_W-1:0]              q_ff;
   logic [1:0]                  pos_ff;
   logic [3:0]                  oc_ff;
   logic [3:0]                  row_ff;
   logic [3:0]                  col_ff;
   logic [crm_pkg::BIAS_W-1:0]  bias_q_ff;
   logic signed [crm_pkg::SAMPLE_W-1:0] px_q_ff;
   logic signed [crm_pkg::SAMPLE_W-1:0] wt_q_ff;
   logic                        rd_vld_ff;
   logic signed [crm_pkg::PROD_W-1:0] prod_ff;
   logic                        prod_vld_ff;
   logic [crm_pkg::ACC_W-1:0]   acc_ff;
   logic [crm_pkg::OUT_W-1:0]   best_ff;
   logic                        out_vld_ff;
   logic [crm_pkg::OUT_W-1:0]   out_val_ff;
   logic [3:0]                  out_oc_ff;
   logic [3:0]                  out_row_ff;
   logic [3:0]                  out_col_ff;

   // FSM outputs
   logic do_accept;
   logic do_load_pos;
   logic do_issue;
   logic do_pool;
   logic do_emit;

   // Address and range decode for the request word
   logic [31:0] pix_addr_w;
   logic [31:0] wt_addr_w;
   logic [31:0] wt_base_w;
   logic [31:0] pos_base_w;
   logic [31:0] oc_w;
   logic        pix_ok;
   logic        wt_ok;
   logic        bias_ok;
   logic        comp_ok;

   assign oc_w       = 32'(req_oc);
   assign pix_addr_w = 32'(req_ic) * 32'(IMG * IMG) + 32'(req_row) * 32'(IMG) + 32'(req_col);
   assign wt_base_w  = 32'(req_oc) * 32'(NUM_CHANNELS * TAPS);
   assign wt_addr_w  = wt_base_w + 32'(req_ic) * 32'(TAPS) + 32'(req_krow) * 32'(KERNEL)
                       + 32'(req_kcol);
   assign pos_base_w = 32'(req_row) * 32'(2 * IMG) + 32'(req_col) * 32'd2;

   assign pix_ok  = (32'(req_ic) < 32'(NUM_CHANNELS)) && (32'(req_row) < 32'(IMG))
                    && (32'(req_col) < 32'(IMG));
   assign wt_ok   = (oc_w < 32'(NUM_CHANNELS)) && (32'(req_ic) < 32'(NUM_CHANNELS))
                    && (32'(req_krow) < 32'(KERNEL)) && (32'(req_kcol) < 32'(KERNEL));
   assign bias_ok = oc_w < 32'(NUM_CHANNELS);
   assign comp_ok = (oc_w < 32'(NUM_CHANNELS)) && (32'(req_row) < 32'(POOL_SIDE))
                    && (32'(req_col) < 32'(POOL_SIDE));

   logic start_compute;
   assign start_compute = do_accept && (req_kind == crm_pkg::REQ_COMPUTE) && comp_ok;

   // End of the channel/tap walk for one conv point
   logic q_last;
   logic p_last;
   logic j_last;
   assign q_last = (q_ff == K_W'(KERNEL - 1));
   assign p_last = (p_ff == K_W'(KERNEL - 1));
   assign j_last = (j_ff == CH_W'(NUM_CHANNELS - 1));

   logic pipe_empty;
   assign pipe_empty = !rd_vld_ff && !prod_vld_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         crm_pkg::ST_IDLE: begin
            if (start_compute) state_in = crm_pkg::ST_LOAD;
         end
         crm_pkg::ST_LOAD:  state_in = crm_pkg::ST_MAC;
         crm_pkg::ST_MAC: begin
            if (q_last && p_last && j_last) state_in = crm_pkg::ST_DRAIN;
         end
         crm_pkg::ST_DRAIN: begin
            if (pipe_empty) state_in = crm_pkg::ST_POOL;
         end
         crm_pkg::ST_POOL: begin
            state_in = (pos_ff == 2'd3) ? crm_pkg::ST_DONE : crm_pkg::ST_LOAD;
         end
         crm_pkg::ST_DONE: begin
            if (!out_vld_ff || rsp_tready) state_in = crm_pkg::ST_IDLE;
         end
         default: state_in = crm_pkg::ST_IDLE;
      endcase
   end

   // FSM outputs
   always_comb begin
      req_tready  = 1'b0;
      do_load_pos = 1'b0;
      do_issue    = 1'b0;
      do_pool     = 1'b0;
      do_emit     = 1'b0;
      case (state_ff)
         crm_pkg::ST_IDLE:  req_tready  = 1'b1;
         crm_pkg::ST_LOAD:  do_load_pos = 1'b1;
         crm_pkg::ST_MAC:   do_issue    = 1'b1;
         crm_pkg::ST_DRAIN: ;
         crm_pkg::ST_POOL:  do_pool     = 1'b1;
         crm_pkg::ST_DONE:  do_emit     = !out_vld_ff || rsp_tready;
         default: ;
      endcase
   end

   assign do_accept = req_tvalid && req_tready;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= crm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Store writes and registered reads
   always_ff @(posedge clock) begin
      if (do_accept && (req_kind == crm_pkg::REQ_PIXEL) && pix_ok) begin
         in_mem[pix_addr_w[IN_AW-1:0]] <= req_sample;
      end
      px_q_ff <= in_mem[in_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (do_accept && (req_kind == crm_pkg::REQ_WEIGHT) && wt_ok) begin
         wt_mem[wt_addr_w[WT_AW-1:0]] <= req_sample;
      end
      wt_q_ff <= wt_mem[wt_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (do_accept && (req_kind == crm_pkg::REQ_BIAS) && bias_ok) begin
         bias_mem[oc_w[CH_W-1:0]] <= req_bias;
      end
      if (req_tready) begin
         bias_q_ff <= bias_mem[oc_w[CH_W-1:0]];
      end
   end

   // Latch the compute word
   always_ff @(posedge clock) begin
      if (start_compute) begin
         pos_base_ff <= pos_base_w[IN_AW-1:0];
         wt_base_ff  <= wt_base_w[WT_AW-1:0];
         oc_ff       <= req_oc;
         row_ff      <= req_row[3:0];
         col_ff      <= req_col[3:0];
      end
   end

   // Walk counters and addresses
   always_ff @(posedge clock) begin
      if (start_compute) begin
         pos_ff <= 2'd0;
      end else if (do_pool) begin
         pos_ff <= pos_ff + 2'd1;
      end
      if (do_load_pos) begin
         in_addr_ff <= pos_base_ff + (pos_ff[1] ? IN_AW'(IMG) : '0)
                       + (pos_ff[0] ? IN_AW'(1) : '0);
         wt_addr_ff <= wt_base_ff;
         j_ff       <= '0;
         p_ff       <= '0;
         q_ff       <= '0;
      end else if (do_issue) begin
         wt_addr_ff <= wt_addr_ff + WT_AW'(1);
         if (!q_last) begin
            q_ff       <= q_ff + K_W'(1);
            in_addr_ff <= in_addr_ff + IN_AW'(1);
         end else begin
            q_ff <= '0;
            if (!p_last) begin
               p_ff       <= p_ff + K_W'(1);
               in_addr_ff <= in_addr_ff + IN_AW'(IN_STEP_ROW);
            end else begin
               p_ff       <= '0;
               j_ff       <= j_ff + CH_W'(1);
               in_addr_ff <= in_addr_ff + IN_AW'(IN_STEP_CH);
            end
         end
      end
   end

   // MAC pipeline: read, multiply, accumulate
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff   <= do_issue;
         prod_vld_ff <= rd_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= px_q_ff * wt_q_ff;
      if (do_load_pos) begin
         acc_ff <= {{EXT_W{bias_q_ff[crm_pkg::BIAS_W-1]}}, bias_q_ff};
      end else if (prod_vld_ff) begin
         acc_ff <= acc_ff + {{PEXT_W{prod_ff[crm_pkg::PROD_W-1]}}, prod_ff};
      end
   end

   // ReLU and saturation of the finished sum
   logic [crm_pkg::OUT_W-1:0] relu_val;
   always_comb begin
      if (acc_ff[crm_pkg::ACC_W-1]) begin
         relu_val = '0;
      end else if (|acc_ff[SAT_HI:crm_pkg::OUT_W]) begin
         relu_val = '1;
      end else begin
         relu_val = acc_ff[crm_pkg::OUT_W-1:0];
      end
   end

   // 2x2 maximum
   always_ff @(posedge clock) begin
      if (start_compute) begin
         best_ff <= '0;
      end else if (do_pool && (relu_val > best_ff)) begin
         best_ff <= relu_val;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (do_emit) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (do_emit) begin
         out_val_ff <= best_ff;
         out_oc_ff  <= oc_ff;
         out_row_ff <= row_ff;
         out_col_ff <= col_ff;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {5'b0, out_val_ff, out_col_ff, out_row_ff, out_oc_ff};

   // Checks
   `ASSERT_CLK(a_idle_pipe_empty, clock, reset, req_tready |-> pipe_empty, "MAC busy while idle")
   `ASSERT_CLK(a_pool_after_drain, clock, reset, do_pool |-> pipe_empty, "pool before drain")
   `ASSERT_CLK(a_load_then_mac, clock, reset,
      state_ff == crm_pkg::ST_LOAD |=> state_ff == crm_pkg::ST_MAC, "load not followed by MAC")
   `ASSERT_NEVER(a_emit_overwrite, clock, reset, do_emit && out_vld_ff && !rsp_tready,
      "result overwritten")

endmodule
